// ----- hw/rtl/lmtf_pkg.sv -----
// lmtf_pkg: shared sizes, command struct and helpers for the move-to-front buffer
// used by lmtf_ctrl, lmtf_datapath and lru_move_to_front_buffer_top
package lmtf_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;

  // fixed field widths
  localparam int KEY_W  = 64;
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int MISS_W = 32;

  // count holds 0..DEPTH
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(4);
  localparam logic [MISS_W-1:0] MISS_MAX  = '1;

  typedef struct packed {
    logic load_key;
    logic compare;
    logic update;
  } lmtf_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } lmtf_state_t;

  // zero reads as one, anything above the depth saturates
  function automatic logic [CNT_BITS-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_BITS-1:0] r;
    if (c == '0) begin
      r = CNT_BITS'(1);
    end else if (int'(c) > DEPTH) begin
      r = CNT_BITS'(DEPTH);
    end else begin
      r = CNT_BITS'(c);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/lmtf_ctrl.sv -----
// lmtf_ctrl: one-hot sequencer for the move-to-front buffer
// depends on lmtf_pkg; drives datapath commands and the channel handshakes
module lmtf_ctrl
  import lmtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lmtf_cmd_t cmd
);

  lmtf_state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMP;
      end
      S_CMP: state_next = S_UPD;
      S_UPD: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall     = (state != S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign cmd.load_key = (state == S_IDLE) && in_valid;
  assign cmd.compare  = (state == S_CMP);
  assign cmd.update   = (state == S_UPD);

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_cmp_then_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |=> cmd.update)
    else $error("compare not followed by update");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_key |=> cmd.compare)
    else $error("accepted beat did not start a compare");

endmodule

// ----- hw/rtl/lmtf_datapath.sv -----
// lmtf_datapath: key shift line, parallel compare, counters and capacity register
// depends on lmtf_pkg; sequenced by lmtf_ctrl through lmtf_cmd_t
module lmtf_datapath
  import lmtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lmtf_cmd_t         cmd,
  input  logic [KEY_W-1:0]  key,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  output logic              hit,
  output logic [MISS_W-1:0] miss_total,
  output logic [OCC_W-1:0]  occupancy
);

  logic [KEY_BITS-1:0] entry_keys [DEPTH];
  logic [KEY_BITS-1:0] key_reg;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] cap;
  logic [MISS_W-1:0]   miss_cnt;
  logic                hit_r;
  logic [DEPTH-1:0]    shift_r;
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    shift_c;
  logic [CNT_BITS-1:0] count_next;

  // valid entries hold distinct keys, so at most one match
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (i < int'(count)) && (entry_keys[i] == key_reg);
    end
  end

  // on a hit only the entries up to the matching one move back
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_c[i] = !(|match) || (|(match >> i));
    end
  end

  always_comb begin
    if (hit_r) begin
      count_next = count;
    end else if (count >= cap) begin
      count_next = cap;
    end else begin
      count_next = count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) key_reg <= key[KEY_BITS-1:0];
    if (cmd.compare) begin
      hit_r   <= |match;
      shift_r <= shift_c;
    end
    if (cmd.update) begin
      entry_keys[0] <= key_reg;
      for (int i = 1; i < DEPTH; i++) begin
        if (shift_r[i]) entry_keys[i] <= entry_keys[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      miss_cnt <= '0;
      cap      <= eff_cap(CAP_RESET);
    end else begin
      if (cfg_wr_en) cap <= eff_cap(cfg_wr_data);
      if (cmd.update) begin
        count <= count_next;
        if (!hit_r && miss_cnt != MISS_MAX) miss_cnt <= miss_cnt + MISS_W'(1);
      end
    end
  end

  assign hit        = hit_r;
  assign miss_total = miss_cnt;
  assign occupancy  = OCC_W'(count);

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key found at more than one position");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    cmd.update && hit_r |=> count == $past(count) && miss_cnt == $past(miss_cnt))
    else $error("hit changed occupancy or miss count");

  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !hit_r |=>
      (miss_cnt == $past(miss_cnt) + MISS_W'(1)) || ($past(miss_cnt) == MISS_MAX))
    else $error("miss not counted");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("occupancy beyond depth");

endmodule

// ----- hw/rtl/lru_move_to_front_buffer_top.sv -----
// an accepted key goes through compare, shift and present steps before its result
// is shown; the sequencer handles one key at a time and stalls input until the
// result is taken
// reset: synchronous active-high rst empties the buffer, clears the miss count
// and sets capacity to 4; no clearing pass, the block is ready right after reset
// lru_move_to_front_buffer_top: joins lmtf_ctrl and lmtf_datapath, uses lmtf_pkg
module lru_move_to_front_buffer_top
  import lmtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output logic [MISS_W-1:0] miss_total,
  output logic [OCC_W-1:0]  occupancy,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data
);

  lmtf_cmd_t cmd;

  lmtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lmtf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key         (key),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .hit         (hit),
    .miss_total  (miss_total),
    .occupancy   (occupancy)
  );

endmodule
